/* rtl/sehtu_pkg.sv */
// ----------------------------------------------------------------------------
// sehtu_pkg
// Shared types and codes for the sorted event handler table.
// ----------------------------------------------------------------------------
package sehtu_pkg;

  // default number of table cells
  localparam int DEFAULT_TABLE_DEPTH = 32;

  // field widths
  localparam int KEY_W = 16;
  localparam int EV_W  = 4;
  localparam int ID_W  = 8;
  localparam int ST_W  = 2;

  // input operation codes
  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_REGISTERED = 2'd0;
  localparam logic [ST_W-1:0] ST_MATCH      = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL       = 2'd2;
  localparam logic [ST_W-1:0] ST_NOMATCH    = 2'd3;

  // wildcard event code
  localparam logic [EV_W-1:0] EV_ANY = 4'd0;

  // one table entry
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [EV_W-1:0]         ev;
    logic [ID_W-1:0]         id;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic   insert;
    logic   rotate;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

/* rtl/sorted_event_handler_table_unit.sv */
// ----------------------------------------------------------------------------
// sorted_event_handler_table_unit
// Stable sorted handler table with event dispatch over a chain of cells.
// ----------------------------------------------------------------------------
// On a registration beat all cells compare the new key at once and the
// entries after the insertion point shift one cell to the right. A
// dispatch beat rotates the whole chain of TABLE_DEPTH cells once through
// cell zero, one entry per cycle while the output side does not stall a
// pending match; matches come out in table order, and the last one is
// flagged. No new input beat is accepted until the dispatch is done. No
// reset sweep is needed: only the entry count and sequencer are cleared.
module sorted_event_handler_table_unit
  import sehtu_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // seq_key[15:0], event_code[19:16], handler_id[27:20], zero pad
  input  logic [31:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // match_id[7:0]
  output logic [7:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] step;
  logic [EV_W-1:0]  disp_ev;
  logic             pend_valid;
  logic [ID_W-1:0]  pend_id;

  logic             out_valid;
  logic [ID_W-1:0]  out_id;
  logic [ST_W-1:0]  out_status;
  logic             out_last;

  entry_t           in_entry;
  cell_ctrl_t       ctrl;
  entry_t           ents [TABLE_DEPTH];
  logic             gts  [TABLE_DEPTH];

  logic             in_beat;
  logic             out_free;
  logic             is_full;
  logic             head_match;
  logic             scan_push;
  logic             scan_adv;
  logic             last_step;

  // input unpacking
  assign in_entry.key = s_axis_tdata[15:0];
  assign in_entry.ev  = s_axis_tdata[19:16];
  assign in_entry.id  = s_axis_tdata[27:20];

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && out_free;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign is_full       = count >= CNT_W'(TABLE_DEPTH);

  // cell zero holds entry number step during a scan
  assign head_match = (CNT_W'(step) < count)
                      && ((ents[0].ev == EV_ANY) || (ents[0].ev == disp_ev));
  assign scan_push  = head_match && pend_valid;
  assign scan_adv   = (state == S_SCAN) && !(scan_push && !out_free);
  assign last_step  = step == IDX_W'(TABLE_DEPTH - 1);

  // broadcast control
  always_comb begin
    ctrl.insert    = in_beat && (s_axis_tuser == OP_REGISTER) && !is_full;
    ctrl.rotate    = scan_adv;
    ctrl.new_entry = in_entry;
  end

  // chain of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic   gt_left;
    entry_t left_entry;
    entry_t right_entry;
    if (i == 0) begin : g_first
      assign gt_left    = 1'b0;
      assign left_entry = ents[0];
    end else begin : g_mid
      assign gt_left    = gts[i-1];
      assign left_entry = ents[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_entry = ents[0];
    end else begin : g_inner
      assign right_entry = ents[i+1];
    end
    sehtu_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (CNT_W'(i) < count),
      .at_count    (CNT_W'(i) == count),
      .gt_left     (gt_left),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .gt          (gts[i]),
      .entry       (ents[i])
    );
  end

  // sequencer and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      step       <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_beat && (s_axis_tuser == OP_DISPATCH)) begin
            state      <= S_SCAN;
            step       <= '0;
            pend_valid <= 1'b0;
          end else if (ctrl.insert) begin
            count <= count + 1'b1;
          end
        end
        S_SCAN: begin
          if (scan_adv) begin
            step <= step + 1'b1;
            if (head_match) begin
              pend_valid <= 1'b1;
            end
            if (last_step) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // held match and dispatch event
  always_ff @(posedge clk) begin
    if (in_beat) begin
      disp_ev <= in_entry.ev;
    end
    if (scan_adv && head_match) begin
      pend_id <= ents[0].id;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((in_beat && (s_axis_tuser == OP_REGISTER))
                 || (scan_adv && scan_push)
                 || ((state == S_FIN) && out_free)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && (s_axis_tuser == OP_REGISTER)) begin
      out_status <= is_full ? ST_FULL : ST_REGISTERED;
      out_id     <= '0;
      out_last   <= 1'b1;
    end else if (scan_adv && scan_push) begin
      out_status <= ST_MATCH;
      out_id     <= pend_id;
      out_last   <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      out_status <= pend_valid ? ST_MATCH : ST_NOMATCH;
      out_id     <= pend_valid ? pend_id : '0;
      out_last   <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_id;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_count_stable_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> $stable(count))
    else $error("entry count changed during dispatch");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |=> (count == $past(count) + 1'b1))
    else $error("registration did not grow the table");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready)
    else $error("input accepted during dispatch");

endmodule

/* rtl/sehtu_cell.sv */
// ----------------------------------------------------------------------------
// sehtu_cell
// One slot of the sorted chain: shifts right on insert, rotates on dispatch.
// ----------------------------------------------------------------------------
module sehtu_cell
  import sehtu_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       at_count,
  input  logic       gt_left,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output logic       gt,
  output entry_t     entry
);

  // occupied slot whose key sorts after the new one
  assign gt = occupied && (entry.key > ctrl.new_entry.key);

  // rotate toward cell zero, or shift and insert
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      entry <= right_entry;
    end else if (ctrl.insert && (gt || at_count)) begin
      entry <= gt_left ? left_entry : ctrl.new_entry;
    end
  end

endmodule
